@@ design/mbr_pkg.sv @@
// ----------------------------------------------------------------------------
// mbr_pkg
// Shared types, constants and the crc-16 byte step for the modbus read master
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mbr_pkg;

  localparam int unsigned MaxWords = 256;
  localparam int unsigned WordIdxW = (MaxWords > 1) ? $clog2(MaxWords) : 1;

  localparam logic [7:0]  FuncReadHolding = 8'h03;
  localparam logic [15:0] CrcPoly         = 16'hA001;
  localparam logic [15:0] CrcInit         = 16'hFFFF;
  localparam logic [9:0]  OverheadBytes   = 10'd5;

  typedef enum logic [1:0] {
    CmdStart = 2'd0,
    CmdByte  = 2'd1,
    CmdEnd   = 2'd2,
    CmdRead  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KindTx     = 2'd0,
    KindStatus = 2'd1,
    KindWord   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StZeroCount = 2'd1,
    StShort     = 2'd2,
    StCrcError  = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] slave_address;
    logic [7:0] start_register;
    logic [7:0] register_count;
    logic [7:0] rx_byte;
    logic [7:0] word_index;
  } item_t;

  typedef struct packed {
    logic        has_res;
    kind_e       kind;
    status_e     status;
    logic [7:0]  word_count;
    logic [15:0] word;
  } rx_res_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ design/mbr_tx.sv @@
// ----------------------------------------------------------------------------
// mbr_tx
// Request frame sequencer: one byte per step, crc built as bytes go out
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbr_tx import mbr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] slave_address_i,
  input  logic [7:0] start_register_i,
  input  logic [7:0] register_count_i,
  input  logic       step_i,
  output logic [7:0] tx_byte_o,
  output logic       last_o
);

  localparam logic [2:0] PosAddr   = 3'd0;
  localparam logic [2:0] PosFunc   = 3'd1;
  localparam logic [2:0] PosRegHi  = 3'd2;
  localparam logic [2:0] PosRegLo  = 3'd3;
  localparam logic [2:0] PosCntHi  = 3'd4;
  localparam logic [2:0] PosCntLo  = 3'd5;
  localparam logic [2:0] PosCrcLo  = 3'd6;
  localparam logic [2:0] PosCrcHi  = 3'd7;

  logic [2:0]  pos_q, pos_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  byte_s;

  always_comb begin
    case (pos_q)
      PosAddr:  byte_s = slave_address_i;
      PosFunc:  byte_s = FuncReadHolding;
      PosRegHi: byte_s = 8'h00;
      PosRegLo: byte_s = start_register_i;
      PosCntHi: byte_s = 8'h00;
      PosCntLo: byte_s = register_count_i;
      PosCrcLo: byte_s = crc_q[7:0];
      PosCrcHi: byte_s = crc_q[15:8];
      default:  byte_s = 8'h00;
    endcase
  end

  always_comb begin
    pos_d = pos_q;
    crc_d = crc_q;
    if (step_i) begin
      pos_d = pos_q + 3'd1;
      if (pos_q == PosCrcHi) begin
        crc_d = CrcInit;
      end else if (pos_q < PosCrcLo) begin
        crc_d = crc_byte(crc_q, byte_s);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= PosAddr;
      crc_q <= CrcInit;
    end else begin
      pos_q <= pos_d;
      crc_q <= crc_d;
    end
  end

  assign tx_byte_o = byte_s;
  assign last_o    = (pos_q == PosCrcHi);

`ifndef SYNTH
  a_crc_init_at_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q == PosAddr |-> crc_q == CrcInit)
    else $error("crc not reset at frame start");
  a_wrap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_o |=> pos_q == PosAddr)
    else $error("sequencer did not wrap after last byte");
  a_hold_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(pos_q) && $stable(crc_q))
    else $error("sequencer moved without a step");
`endif

endmodule

@@ design/mbr_rx.sv @@
// ----------------------------------------------------------------------------
// mbr_rx
// Response parser: crc check, byte count cap, payload store and word reads
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbr_rx import mbr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  item_t               item_i,
  input  logic                commit_i,
  input  logic                rd_en_i,
  input  logic [WordIdxW-1:0] rd_addr_i,
  output rx_res_t             res_o
);

  typedef enum logic [1:0] {
    PhIdle = 2'd0,
    PhRx   = 2'd1
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [9:0]  exp_q, exp_d;
  logic [9:0]  rcv_q, rcv_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  pbc_q, pbc_d;
  logic [7:0]  hold_q, hold_d;
  logic [7:0]  valid_q, valid_d;

  logic [15:0] store_q [MaxWords];
  logic [15:0] rd_q;

  logic                we_s;
  logic [WordIdxW-1:0] waddr_s;
  logic [15:0]         wdata_s;

  logic [9:0]  span_s;
  logic [9:0]  rcv_inc_s;
  logic [9:0]  off_s;
  logic [15:0] crc_n_s;
  logic [8:0]  wc_s;

  always_comb begin
    phase_d = phase_q;
    exp_d   = exp_q;
    rcv_d   = rcv_q;
    crc_d   = crc_q;
    pbc_d   = pbc_q;
    hold_d  = hold_q;
    valid_d = valid_q;
    we_s    = 1'b0;
    wdata_s = {hold_q, item_i.rx_byte};
    res_o   = '{has_res: 1'b0, kind: KindStatus, status: StOk,
                word_count: 8'h00, word: 16'h0000};

    span_s    = exp_q - OverheadBytes;
    rcv_inc_s = rcv_q + 10'd1;
    off_s     = rcv_q - 10'd3;
    crc_n_s   = crc_byte(crc_q, item_i.rx_byte);
    wc_s      = {1'b0, pbc_q} >> 1;
    waddr_s   = off_s[WordIdxW:1];

    case (item_i.cmd)
      CmdStart: begin
        valid_d = 8'h00;
        res_o.has_res = 1'b1;
        if (item_i.register_count == 8'h00) begin
          phase_d = PhIdle;
          res_o.status = StZeroCount;
        end else begin
          phase_d = PhRx;
          res_o.kind = KindTx;
          exp_d   = OverheadBytes + {1'b0, item_i.register_count, 1'b0};
          rcv_d   = 10'd0;
          crc_d   = CrcInit;
          pbc_d   = 8'h00;
          hold_d  = 8'h00;
        end
      end
      CmdByte: begin
        if (phase_q == PhRx) begin
          crc_d = crc_n_s;
          rcv_d = rcv_inc_s;
          if (rcv_q == 10'd2) begin
            pbc_d = ({2'b00, item_i.rx_byte} < span_s) ? item_i.rx_byte : span_s[7:0];
          end else if (rcv_q >= 10'd3) begin
            if (!off_s[0]) begin
              hold_d = item_i.rx_byte;
            end else if (off_s[9:1] < wc_s && {1'b0, off_s[9:1]} < 10'(MaxWords)) begin
              we_s = 1'b1;
            end
          end
          if (rcv_inc_s >= exp_q) begin
            phase_d = PhIdle;
            res_o.has_res = 1'b1;
            if (crc_n_s == 16'h0000) begin
              valid_d = (10'(wc_s) > 10'(MaxWords)) ? 8'(MaxWords) : wc_s[7:0];
              res_o.word_count = valid_d;
            end else begin
              valid_d = 8'h00;
              res_o.status = StCrcError;
            end
          end
        end
      end
      CmdEnd: begin
        if (phase_q == PhRx) begin
          phase_d = PhIdle;
          valid_d = 8'h00;
          res_o.has_res = 1'b1;
          res_o.status  = StShort;
        end
      end
      CmdRead: begin
        res_o.has_res = 1'b1;
        res_o.kind    = KindWord;
        if (item_i.word_index < valid_q && 9'(item_i.word_index) < 9'(MaxWords)) begin
          res_o.word = rd_q;
        end
      end
      default: begin
        res_o.has_res = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      exp_q   <= 10'd0;
      rcv_q   <= 10'd0;
      crc_q   <= CrcInit;
      pbc_q   <= 8'h00;
      hold_q  <= 8'h00;
      valid_q <= 8'h00;
    end else if (commit_i) begin
      phase_q <= phase_d;
      exp_q   <= exp_d;
      rcv_q   <= rcv_d;
      crc_q   <= crc_d;
      pbc_q   <= pbc_d;
      hold_q  <= hold_d;
      valid_q <= valid_d;
    end
  end

  // payload store, registered read taken when the read item is accepted
  always_ff @(posedge clk_i) begin
    if (commit_i && we_s) begin
      store_q[waddr_s] <= wdata_s;
    end
    if (rd_en_i) begin
      rd_q <= store_q[rd_addr_i];
    end
  end

`ifndef SYNTH
  a_no_words_while_rx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhRx |-> valid_q == 8'h00)
    else $error("valid words nonzero during reception");
  a_rcv_below_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhRx |-> rcv_q < exp_q)
    else $error("received length reached expected while receiving");
  a_write_only_in_rx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit_i && we_s |-> phase_q == PhRx && item_i.cmd == CmdByte)
    else $error("payload write outside reception");
`endif

endmodule

@@ design/modbus_rtu_read_holding_master_top.sv @@
// ----------------------------------------------------------------------------
// modbus_rtu_read_holding_master_top
// Modbus rtu read holding registers master, request builder and response check
// ----------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid_i/in_ready_o): one command per transfer: start,
//     received byte, end of reception or read of a stored word.
//   out channel (out_valid_o/out_ready_i): result items; last_o marks the
//     final result caused by one command.
//   A start with a nonzero count gives eight transmit bytes, one per cycle
//     while out_ready_i is high, the crc built byte by byte as they leave;
//     in_ready_o stays low until the eighth byte, and the next command is
//     taken with that byte. Every other command gives at most one result.
//   Path: a command goes into the input register, its result into the
//     output register. Single-result commands flow at one per cycle while
//     out_ready_i is high; the store read is issued as the command is taken.
//   Reset: idle, no valid words, empty output; the payload store is not
//     cleared and needs no clearing pass.
//   Receiver stall: the output register holds its item, the input register
//     fills behind it, then in_ready_o drops until out_ready_i returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module modbus_rtu_read_holding_master_top import mbr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [7:0]  slave_address_i,
  input  logic [7:0]  start_register_i,
  input  logic [7:0]  register_count_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [7:0]  word_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  tx_byte_o,
  output logic [1:0]  status_o,
  output logic [7:0]  word_count_o,
  output logic [15:0] register_word_o,
  output logic        last_o
);

  logic    s1_valid_q;
  item_t   s1_q;
  rx_res_t rx_res_s;

  logic        tx_last_s;
  logic [7:0]  tx_byte_s;
  logic        slot_free_s;
  logic        is_frame_s;
  logic        emit_s;
  logic        s1_done_s;
  logic        accept_s;

  logic        out_valid_q;
  kind_e       kind_q;
  logic [7:0]  tx_byte_q;
  status_e     status_q;
  logic [7:0]  word_count_q;
  logic [15:0] word_q;
  logic        last_q;

  assign slot_free_s = !out_valid_q || out_ready_i;
  assign is_frame_s  = (s1_q.cmd == CmdStart) && (s1_q.register_count != 8'h00);
  assign emit_s      = s1_valid_q && rx_res_s.has_res && slot_free_s;
  assign s1_done_s   = s1_valid_q &&
                       (!rx_res_s.has_res || (slot_free_s && (!is_frame_s || tx_last_s)));
  assign in_ready_o  = !s1_valid_q || s1_done_s;
  assign accept_s    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_s) begin
      s1_q <= '{cmd: cmd_e'(command_i), slave_address: slave_address_i,
                start_register: start_register_i, register_count: register_count_i,
                rx_byte: rx_byte_i, word_index: word_index_i};
    end
  end

  mbr_rx u_rx (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (s1_q),
    .commit_i  (s1_done_s),
    .rd_en_i   (accept_s),
    .rd_addr_i (word_index_i[WordIdxW-1:0]),
    .res_o     (rx_res_s)
  );

  mbr_tx u_tx (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .slave_address_i  (s1_q.slave_address),
    .start_register_i (s1_q.start_register),
    .register_count_i (s1_q.register_count),
    .step_i           (emit_s && is_frame_s),
    .tx_byte_o        (tx_byte_s),
    .last_o           (tx_last_s)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_s) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_s) begin
      if (is_frame_s) begin
        kind_q       <= KindTx;
        tx_byte_q    <= tx_byte_s;
        status_q     <= StOk;
        word_count_q <= 8'h00;
        word_q       <= 16'h0000;
        last_q       <= tx_last_s;
      end else begin
        kind_q       <= rx_res_s.kind;
        tx_byte_q    <= 8'h00;
        status_q     <= rx_res_s.status;
        word_count_q <= rx_res_s.word_count;
        word_q       <= rx_res_s.word;
        last_q       <= 1'b1;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign tx_byte_o       = tx_byte_q;
  assign status_o        = status_q;
  assign word_count_o    = word_count_q;
  assign register_word_o = word_q;
  assign last_o          = last_q;

`ifndef SYNTH
  a_no_emit_over_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !emit_s)
    else $error("result written over a waiting result");
  a_frame_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_s && is_frame_s && !tx_last_s |-> !in_ready_o)
    else $error("input taken in the middle of a request frame");
  a_tx_kind_only_frames: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_s && !is_frame_s |-> rx_res_s.kind != KindTx)
    else $error("transmit result outside a request frame");
`endif

endmodule

@@ tb/modbus_rtu_read_holding_master_top_tb.sv @@
// ----------------------------------------------------------------------------
// modbus_rtu_read_holding_master_top_tb
// Self-checking bench for the modbus rtu read holding registers master
// ----------------------------------------------------------------------------
// A short table of commands covers reads after reset, ignored bytes, a zero
// count, a short response, a capped byte count, a start while receiving and
// a crc mismatch. Random request/response exchanges, broken exchanges and
// noise follow. Each transfer on the command side runs through a predictor
// of the request frame, crc residue and word store; every result transfer is
// compared with the oldest predicted result. Sender gaps and receiver stalls
// change across phases, with one long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module modbus_rtu_read_holding_master_top_tb;
  import mbr_pkg::*;

  localparam int RandItems     = 200;
  localparam int StuckLimit    = 1000;
  localparam int HoldOffCycles = 150;

  typedef struct {
    cmd_e       cmd;
    logic [7:0] addr;
    logic [7:0] start_reg;
    logic [7:0] cnt;
    logic [7:0] rxb;
    logic [7:0] idx;
  } master_cmd_t;

  typedef struct {
    kind_e       kind;
    logic [7:0]  tx;
    status_e     st;
    logic [7:0]  wc;
    logic [15:0] word;
    logic        last;
  } master_out_t;

  typedef struct {
    master_cmd_t c;
    int          typed;
    master_out_t r;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  command_i = '0;
  logic [7:0]  slave_address_i = '0;
  logic [7:0]  start_register_i = '0;
  logic [7:0]  register_count_i = '0;
  logic [7:0]  rx_byte_i = '0;
  logic [7:0]  word_index_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  kind_o;
  logic [7:0]  tx_byte_o;
  logic [1:0]  status_o;
  logic [7:0]  word_count_o;
  logic [15:0] register_word_o;
  logic        last_o;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off_req = 1'b0;
  int hold_left = 0;
  int stuck_cycles = 0;
  int fail_count = 0;
  int stim_count = 0;

  master_out_t master_outputs_q[$];

  // predictor state
  bit          rx_busy = 1'b0;
  logic [9:0]  want_len = '0;
  logic [9:0]  got_len = '0;
  logic [15:0] rx_crc = CrcInit;
  logic [7:0]  pay_bytes = '0;
  logic [7:0]  hi_byte = '0;
  logic [15:0] word_store [MaxWords];
  int unsigned words_valid = 0;

  modbus_rtu_read_holding_master_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .command_i        (command_i),
    .slave_address_i  (slave_address_i),
    .start_register_i (start_register_i),
    .register_count_i (register_count_i),
    .rx_byte_i        (rx_byte_i),
    .word_index_i     (word_index_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .tx_byte_o        (tx_byte_o),
    .status_o         (status_o),
    .word_count_o     (word_count_o),
    .register_word_o  (register_word_o),
    .last_o           (last_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    repeat (8) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  function automatic void push_out(input bit record, input kind_e k, input logic [7:0] tx,
                                   input status_e s, input logic [7:0] wc,
                                   input logic [15:0] w, input logic last);
    master_out_t o;
    if (!record) return;
    o.kind = k;
    o.tx   = tx;
    o.st   = s;
    o.wc   = wc;
    o.word = w;
    o.last = last;
    master_outputs_q.push_back(o);
  endfunction

  function automatic void master_step(input master_cmd_t c, input bit record);
    logic [7:0]  frame [8];
    logic [15:0] fcrc;
    logic [9:0]  pos;
    logic [9:0]  span;
    logic [9:0]  q;
    logic [8:0]  w;
    case (c.cmd)
      CmdStart: begin
        words_valid = 0;
        if (c.cnt == 8'd0) begin
          rx_busy = 1'b0;
          push_out(record, KindStatus, 8'h00, StZeroCount, 8'h00, 16'h0000, 1'b1);
        end else begin
          frame = '{c.addr, FuncReadHolding, 8'h00, c.start_reg, 8'h00, c.cnt, 8'h00, 8'h00};
          fcrc = CrcInit;
          for (int i = 0; i < 6; i++) fcrc = crc16_step(fcrc, frame[i]);
          frame[6] = fcrc[7:0];
          frame[7] = fcrc[15:8];
          for (int i = 0; i < 8; i++) begin
            push_out(record, KindTx, frame[i], StOk, 8'h00, 16'h0000, i == 7);
          end
          rx_busy   = 1'b1;
          want_len  = OverheadBytes + {1'b0, c.cnt, 1'b0};
          got_len   = '0;
          rx_crc    = CrcInit;
          pay_bytes = '0;
          hi_byte   = '0;
        end
      end
      CmdByte: begin
        if (!rx_busy) return;
        pos     = got_len;
        span    = want_len - OverheadBytes;
        rx_crc  = crc16_step(rx_crc, c.rxb);
        got_len = got_len + 10'd1;
        if (pos == 10'd2) begin
          // byte count field, capped at twice the register count
          pay_bytes = ({2'b00, c.rxb} < span) ? c.rxb : span[7:0];
        end else if (pos >= 10'd3) begin
          q = pos - 10'd3;
          if (!q[0]) begin
            hi_byte = c.rxb;
          end else begin
            w = q[9:1];
            if (w < pay_bytes[7:1] && w < MaxWords) word_store[w] = {hi_byte, c.rxb};
          end
        end
        if (got_len >= want_len) begin
          rx_busy = 1'b0;
          if (rx_crc == 16'h0000) begin
            words_valid = pay_bytes[7:1];
            push_out(record, KindStatus, 8'h00, StOk, {1'b0, pay_bytes[7:1]}, 16'h0000, 1'b1);
          end else begin
            words_valid = 0;
            push_out(record, KindStatus, 8'h00, StCrcError, 8'h00, 16'h0000, 1'b1);
          end
        end
      end
      CmdEnd: begin
        if (!rx_busy) return;
        rx_busy     = 1'b0;
        words_valid = 0;
        push_out(record, KindStatus, 8'h00, StShort, 8'h00, 16'h0000, 1'b1);
      end
      default: begin
        push_out(record, KindWord, 8'h00, StOk, 8'h00,
                 (c.idx < words_valid) ? word_store[c.idx] : 16'h0000, 1'b1);
      end
    endcase
  endfunction

  function automatic master_cmd_t rand_cmd(input cmd_e cmd);
    master_cmd_t c;
    c.cmd       = cmd;
    c.addr      = 8'($urandom);
    c.start_reg = 8'($urandom);
    c.cnt       = 8'($urandom);
    c.rxb       = 8'($urandom);
    c.idx       = 8'($urandom);
    return c;
  endfunction

  function automatic dir_row_t mk_row(input cmd_e cmd, input logic [7:0] a,
                                      input logic [7:0] sr, input logic [7:0] n,
                                      input logic [7:0] b, input logic [7:0] i,
                                      input int typed, input kind_e k, input status_e s,
                                      input logic [15:0] w);
    dir_row_t row;
    row.c      = '{cmd, a, sr, n, b, i};
    row.typed  = typed;
    row.r.kind = k;
    row.r.tx   = 8'h00;
    row.r.st   = s;
    row.r.wc   = 8'h00;
    row.r.word = w;
    row.r.last = 1'b1;
    return row;
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("mismatch: %s", msg);
  endfunction

  task automatic offer_cmd(input master_cmd_t c, input bit record);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    command_i        <= c.cmd;
    slave_address_i  <= c.addr;
    start_register_i <= c.start_reg;
    register_count_i <= c.cnt;
    rx_byte_i        <= c.rxb;
    word_index_i     <= c.idx;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (!((c.cmd == CmdByte || c.cmd == CmdEnd) && !rx_busy)) stim_count++;
    master_step(c, record);
  endtask

  // receiver side: random stalls plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (hold_off_req) begin
      hold_off_req = 1'b0;
      hold_left = HoldOffCycles;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result check
  always @(posedge clk_i) begin
    master_out_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (master_outputs_q.size() == 0) begin
        note_failure($sformatf("unexpected result kind %0d tx %h st %0d wc %0d word %h last %b",
                               kind_o, tx_byte_o, status_o, word_count_o, register_word_o,
                               last_o));
      end else begin
        e = master_outputs_q.pop_front();
        if (kind_o !== e.kind || tx_byte_o !== e.tx || status_o !== e.st ||
            word_count_o !== e.wc || register_word_o !== e.word || last_o !== e.last) begin
          note_failure($sformatf({"exp kind %0d tx %h st %0d wc %0d word %h last %b, ",
                                  "got kind %0d tx %h st %0d wc %0d word %h last %b"},
                                 e.kind, e.tx, e.st, e.wc, e.word, e.last,
                                 kind_o, tx_byte_o, status_o, word_count_o,
                                 register_word_o, last_o));
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= StuckLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    dir_row_t    dir_rows[$];
    logic [15:0] good_crc;
    logic [15:0] bad_crc;
    logic [7:0]  resp[$];
    logic [15:0] fcrc;
    master_cmd_t c;
    int unsigned pick;
    int unsigned n;
    int unsigned k;
    int          ph;
    bit          hold_done;

    hold_done = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    good_crc = CrcInit;
    foreach (resp[j]) good_crc = good_crc;
    for (int j = 0; j < 5; j++) begin
      good_crc = crc16_step(good_crc, (j == 0) ? 8'h11 : (j == 1) ? 8'h03 :
                                      (j == 2) ? 8'hFF : (j == 3) ? 8'hAB : 8'hCD);
    end
    bad_crc = CrcInit;
    for (int j = 0; j < 5; j++) begin
      bad_crc = crc16_step(bad_crc, (j == 0) ? 8'h01 : (j == 1) ? 8'h03 :
                                    (j == 2) ? 8'h02 : (j == 3) ? 8'hFF : 8'h00);
    end
    bad_crc ^= 16'h8001;

    // read after reset, ignored bytes, zero count, short response
    dir_rows.push_back(mk_row(CmdRead,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00,  1, KindWord,   StOk, 16'h0));
    dir_rows.push_back(mk_row(CmdByte,  8'h00, 8'h00, 8'h00, 8'hFF, 8'h00,  0, KindWord,   StOk, 16'h0));
    dir_rows.push_back(mk_row(CmdEnd,   8'h00, 8'h00, 8'h00, 8'h00, 8'h00,  0, KindWord,   StOk, 16'h0));
    dir_rows.push_back(mk_row(CmdStart, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,  1, KindStatus,
                              StZeroCount, 16'h0));
    dir_rows.push_back(mk_row(CmdStart, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, -1, KindTx, StOk, 16'h0));
    dir_rows.push_back(mk_row(CmdEnd,   8'h00, 8'h00, 8'h00, 8'h00, 8'h00,  1, KindStatus,
                              StShort, 16'h0));
    // good response with the byte count field capped from 0xff to 2
    dir_rows.push_back(mk_row(CmdStart, 8'h11, 8'h6B, 8'h01, 8'h00, 8'h00, -1, KindTx, StOk, 16'h0));
    dir_rows.push_back(mk_row(CmdByte, 8'h00, 8'h00, 8'h00, 8'h11, 8'h00, -1, KindTx, StOk, 16'h0));
    dir_rows.push_back(mk_row(CmdByte, 8'h00, 8'h00, 8'h00, 8'h03, 8'h00, -1, KindTx, StOk, 16'h0));
    dir_rows.push_back(mk_row(CmdByte, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, -1, KindTx, StOk, 16'h0));
    dir_rows.push_back(mk_row(CmdByte, 8'h00, 8'h00, 8'h00, 8'hAB, 8'h00, -1, KindTx, StOk, 16'h0));
    dir_rows.push_back(mk_row(CmdByte, 8'h00, 8'h00, 8'h00, 8'hCD, 8'h00, -1, KindTx, StOk, 16'h0));
    dir_rows.push_back(mk_row(CmdByte, 8'h00, 8'h00, 8'h00, good_crc[7:0], 8'h00, -1, KindTx,
                              StOk, 16'h0));
    dir_rows.push_back(mk_row(CmdByte, 8'h00, 8'h00, 8'h00, good_crc[15:8], 8'h00, -1, KindTx,
                              StOk, 16'h0));
    dir_rows.push_back(mk_row(CmdRead, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, -1, KindWord, StOk, 16'h0));
    dir_rows.push_back(mk_row(CmdRead, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF,  1, KindWord, StOk, 16'h0));
    // a start clears the stored words; a second start drops the first
    dir_rows.push_back(mk_row(CmdStart, 8'h01, 8'h00, 8'h01, 8'h00, 8'h00, -1, KindTx, StOk, 16'h0));
    dir_rows.push_back(mk_row(CmdRead,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00,  1, KindWord, StOk, 16'h0));
    dir_rows.push_back(mk_row(CmdStart, 8'h01, 8'h00, 8'h01, 8'h00, 8'h00, -1, KindTx, StOk, 16'h0));
    // response with a corrupted crc
    dir_rows.push_back(mk_row(CmdByte, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, -1, KindTx, StOk, 16'h0));
    dir_rows.push_back(mk_row(CmdByte, 8'h00, 8'h00, 8'h00, 8'h03, 8'h00, -1, KindTx, StOk, 16'h0));
    dir_rows.push_back(mk_row(CmdByte, 8'h00, 8'h00, 8'h00, 8'h02, 8'h00, -1, KindTx, StOk, 16'h0));
    dir_rows.push_back(mk_row(CmdByte, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, -1, KindTx, StOk, 16'h0));
    dir_rows.push_back(mk_row(CmdByte, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, -1, KindTx, StOk, 16'h0));
    dir_rows.push_back(mk_row(CmdByte, 8'h00, 8'h00, 8'h00, bad_crc[7:0], 8'h00, -1, KindTx,
                              StOk, 16'h0));
    dir_rows.push_back(mk_row(CmdByte, 8'h00, 8'h00, 8'h00, bad_crc[15:8], 8'h00, 1, KindStatus,
                              StCrcError, 16'h0));

    foreach (dir_rows[r]) begin
      offer_cmd(dir_rows[r].c, dir_rows[r].typed < 0);
      if (dir_rows[r].typed > 0) master_outputs_q.push_back(dir_rows[r].r);
    end

    stim_count = 0;
    while (stim_count < RandItems) begin
      ph = stim_count * 4 / RandItems;
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 63;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 63;
        end
        default: begin
          send_idle_pct  = 21;
          recv_stall_pct = 21;
        end
      endcase
      if (ph == 2 && !hold_done) begin
        hold_off_req = 1'b1;
        hold_done = 1'b1;
      end

      pick = $urandom_range(99);
      if (pick < 60) begin
        // well-formed exchange with random content
        n = ($urandom_range(9) == 0) ? $urandom_range(20, 7) : $urandom_range(4, 1);
        c = rand_cmd(CmdStart);
        c.cnt = 8'(n);
        offer_cmd(c, 1'b1);
        resp.delete();
        resp.push_back(($urandom_range(9) == 0) ? 8'($urandom) : c.addr);
        resp.push_back(($urandom_range(9) == 0) ? 8'($urandom) : FuncReadHolding);
        resp.push_back(($urandom_range(3) == 0) ? 8'($urandom) : 8'(2 * n));
        repeat (2 * n) resp.push_back(8'($urandom));
        fcrc = CrcInit;
        foreach (resp[j]) fcrc = crc16_step(fcrc, resp[j]);
        resp.push_back(fcrc[7:0]);
        resp.push_back(fcrc[15:8]);
        if ($urandom_range(5) == 0) begin
          k = $urandom_range(resp.size() - 1);
          resp[k] ^= 8'(1 << $urandom_range(7));
        end
        foreach (resp[j]) begin
          c = rand_cmd(CmdByte);
          c.rxb = resp[j];
          offer_cmd(c, 1'b1);
        end
        repeat ($urandom_range(3)) begin
          c = rand_cmd(CmdRead);
          if ($urandom_range(3) != 0) c.idx = 8'($urandom_range(n));
          offer_cmd(c, 1'b1);
        end
      end else if (pick < 75) begin
        // broken exchange: cut short or left open
        c = rand_cmd(CmdStart);
        if ($urandom_range(3) == 0) c.cnt = 8'hFF;
        else if (c.cnt == 8'd0) c.cnt = 8'd1;
        offer_cmd(c, 1'b1);
        repeat ($urandom_range(6)) begin
          c = rand_cmd(CmdByte);
          offer_cmd(c, 1'b1);
        end
        if ($urandom_range(3) != 0) begin
          c = rand_cmd(CmdEnd);
          offer_cmd(c, 1'b1);
        end
      end else begin
        c = rand_cmd(cmd_e'($urandom_range(3)));
        if (c.cmd == CmdStart) c.cnt = 8'd0;
        offer_cmd(c, 1'b1);
      end
    end
    in_valid_i <= 1'b0;

    while (master_outputs_q.size() != 0) @(posedge clk_i);
    recv_stall_pct = 0;
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/mbr_pkg.sv
design/mbr_tx.sv
design/mbr_rx.sv
design/modbus_rtu_read_holding_master_top.sv
tb/modbus_rtu_read_holding_master_top_tb.sv
